// ===== rtl/bgr_pkg.sv =====
// Shared types, codes and lookup functions for the tile background renderer.
`timescale 1ns / 1ps

package bgr_pkg;

	localparam int ATTR_BYTES      = 64;
	localparam int ATTR_AW         = 6;
	localparam int PALETTE_ENTRIES = 32;
	localparam int PALETTE_AW      = 5;
	localparam int COLOUR_W        = 6;
	localparam int RGB_W           = 24;

	typedef enum logic [2:0] {
		CMD_RENDER  = 3'd0,
		CMD_TILE    = 3'd1,
		CMD_ATTR    = 3'd2,
		CMD_PATTERN = 3'd3,
		CMD_PALETTE = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		CFG_ENABLE  = 2'd0,
		CFG_HSCROLL = 2'd1,
		CFG_VSCROLL = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic        valid;
		cmd_t        cmd;
		logic [11:0] addr;
		logic [7:0]  data;
	} item_t;

	// Reduce v modulo m by conditional subtraction of m*8, m*4, m*2, m; needs v < 16*m.
	function automatic logic [12:0] wrap_mod(input logic [12:0] v, input logic [12:0] m);
		logic [12:0] r;
		logic [12:0] step;
		r = v;
		for (int k = 3; k >= 0; k--) begin
			step = m << k;
			if (r >= step) begin
				r = r - step;
			end
		end
		return r;
	endfunction

	function automatic logic [RGB_W-1:0] master_rgb(input logic [COLOUR_W-1:0] idx);
		case (idx)
			6'd0:  return 24'h545454;
			6'd1:  return 24'h001E74;
			6'd2:  return 24'h081090;
			6'd3:  return 24'h300088;
			6'd4:  return 24'h440064;
			6'd5:  return 24'h5C0030;
			6'd6:  return 24'h540400;
			6'd7:  return 24'h3C1800;
			6'd8:  return 24'h202A00;
			6'd9:  return 24'h083A00;
			6'd10: return 24'h004000;
			6'd11: return 24'h003C00;
			6'd12: return 24'h00323C;
			6'd13: return 24'h000000;
			6'd14: return 24'h000000;
			6'd15: return 24'h000000;
			6'd16: return 24'h989698;
			6'd17: return 24'h084CC4;
			6'd18: return 24'h3032EC;
			6'd19: return 24'h5C1EE4;
			6'd20: return 24'h8800B0;
			6'd21: return 24'hA00060;
			6'd22: return 24'h981A20;
			6'd23: return 24'h783C00;
			6'd24: return 24'h545A00;
			6'd25: return 24'h207200;
			6'd26: return 24'h007C00;
			6'd27: return 24'h007628;
			6'd28: return 24'h006678;
			6'd29: return 24'h000000;
			6'd30: return 24'h000000;
			6'd31: return 24'h000000;
			6'd32: return 24'hECEEEC;
			6'd33: return 24'h4C9AEC;
			6'd34: return 24'h787CEC;
			6'd35: return 24'hB062EC;
			6'd36: return 24'hE400DC;
			6'd37: return 24'hEC0078;
			6'd38: return 24'hEC3C30;
			6'd39: return 24'hCC6C00;
			6'd40: return 24'h8C9000;
			6'd41: return 24'h48A800;
			6'd42: return 24'h10B800;
			6'd43: return 24'h00B260;
			6'd44: return 24'h00A2C4;
			6'd45: return 24'h4C4C4C;
			6'd46: return 24'h000000;
			6'd47: return 24'h000000;
			6'd48: return 24'hECEEEC;
			6'd49: return 24'hA8CCEC;
			6'd50: return 24'hBCBCEC;
			6'd51: return 24'hD4B2EC;
			6'd52: return 24'hECAEEC;
			6'd53: return 24'hECAED4;
			6'd54: return 24'hECB4B0;
			6'd55: return 24'hE4C490;
			6'd56: return 24'hCCD278;
			6'd57: return 24'hB4DE78;
			6'd58: return 24'hA8E290;
			6'd59: return 24'h98E2B4;
			6'd60: return 24'hA0D6E4;
			6'd61: return 24'hA0A2A0;
			6'd62: return 24'h000000;
			6'd63: return 24'h000000;
			default: return 24'h000000;
		endcase
	endfunction

endpackage

// ===== rtl/bgr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bgr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/bgr_scroll.sv =====
// Scroll stage: adds the scroll offsets and wraps the position around the map.
`timescale 1ns / 1ps

module bgr_scroll #(
	parameter int MAP_COLUMNS = 32,
	parameter int MAP_ROWS    = 30
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                adv,
	input  bgr_pkg::item_t                      item_s1,
	input  logic [7:0]                          px_s1,
	input  logic [7:0]                          py_s1,
	input  logic [7:0]                          ro_s1,
	input  logic [7:0]                          hscroll,
	input  logic [7:0]                          vscroll,
	output bgr_pkg::item_t                      item_s2,
	output logic [$clog2(MAP_COLUMNS*8)-1:0]    wx_s2,
	output logic [$clog2(MAP_ROWS*8)-1:0]       wy_s2
);

	import bgr_pkg::*;

	localparam int XW = MAP_COLUMNS * 8;
	localparam int YW = MAP_ROWS * 8;
	localparam int XB = $clog2(XW);
	localparam int YB = $clog2(YW);

	logic [9:0]  sum_x;
	logic [9:0]  sum_y;
	logic [12:0] wrap_x;
	logic [12:0] wrap_y;

	always_comb begin
		sum_x  = 10'(px_s1) + 10'(hscroll) + 10'(ro_s1);
		sum_y  = 10'(py_s1) + 10'(vscroll);
		wrap_x = wrap_mod(13'(sum_x), 13'(XW));
		wrap_y = wrap_mod(13'(sum_y), 13'(YW));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s2.valid <= 1'b0;
		end else if (adv) begin
			item_s2 <= item_s1;
			wx_s2   <= wrap_x[XB-1:0];
			wy_s2   <= wrap_y[YB-1:0];
		end
	end

endmodule

// ===== rtl/bgr_colour.sv =====
// Output stage: master colour lookup, enable masking and output register.
`timescale 1ns / 1ps

module bgr_colour (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             adv,
	input  logic                             enable,
	input  bgr_pkg::item_t                   item_s5,
	input  logic                             opaque_s5,
	input  logic [bgr_pkg::COLOUR_W-1:0]     colour_rd,
	output logic                             out_valid,
	output logic [bgr_pkg::RGB_W-1:0]        rgb_color,
	output logic                             is_opaque,
	output logic                             pixel_written
);

	import bgr_pkg::*;

	logic             out_valid_q;
	logic [RGB_W-1:0] rgb_q;
	logic             opaque_q;
	logic             written_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= item_s5.valid && (item_s5.cmd == CMD_RENDER);
			rgb_q       <= enable ? master_rgb(colour_rd) : '0;
			opaque_q    <= enable && opaque_s5;
			written_q   <= enable;
		end
	end

	assign out_valid     = out_valid_q;
	assign rgb_color     = rgb_q;
	assign is_opaque     = opaque_q;
	assign pixel_written = written_q;

endmodule

// ===== rtl/tile_background_pixel_renderer_top.sv =====
// Tile background pixel renderer: top level with stores and pipeline control.
// A render word passes the input register, the scroll register, the tile and attribute reads, the pattern
// plane reads, the palette read and the output register. Throughput: one word per cycle while the output
// is not stalled; each store has its own RAMs and is read once per word. A stall on the output freezes the
// whole pipeline and stalls the input. Reset (arst_n, asynchronous) clears the valid bits and the configuration
// registers; the stores are not cleared and hold nothing meaningful until written.
`timescale 1ns / 1ps

module tile_background_pixel_renderer_top #(
	parameter int MAP_COLUMNS = 32,
	parameter int MAP_ROWS    = 30,
	parameter int TILE_COUNT  = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [11:0] mem_addr,
	input  logic [7:0]  write_byte,
	input  logic [7:0]  pixel_x,
	input  logic [7:0]  pixel_y,
	input  logic [7:0]  row_offset,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [23:0] rgb_color,
	output logic        is_opaque,
	output logic        pixel_written
);

	import bgr_pkg::*;

	localparam int XB        = $clog2(MAP_COLUMNS * 8);
	localparam int YB        = $clog2(MAP_ROWS * 8);
	localparam int CELLS     = MAP_COLUMNS * MAP_ROWS;
	localparam int TAB       = $clog2(CELLS);
	localparam int TB        = $clog2(TILE_COUNT);
	localparam int PB        = TB + 3;
	localparam int PAT_BYTES = TILE_COUNT * 16;

	logic        enable_q;
	logic [7:0]  hscroll_q;
	logic [7:0]  vscroll_q;
	logic        adv;

	item_t       item_s1, item_s2, item_s3, item_s4, item_s5;
	logic [7:0]  px_s1, py_s1, ro_s1;
	logic [XB-1:0] wx_s2;
	logic [YB-1:0] wy_s2;
	logic [2:0]  fx_s3, fy_s3, fx_s4;
	logic [1:0]  sel_s3;
	logic [1:0]  pal_s4;
	logic        opaque_s5;

	logic [XB-4:0]  tx;
	logic [YB-4:0]  ty;
	logic [TAB-1:0] tile_raddr;
	logic [ATTR_AW-1:0] attr_raddr;
	logic        tile_we, attr_we;
	logic [7:0]  tile_rd, attr_rd;
	logic [12:0] tile_wrap;
	logic [PB-1:0] pat_raddr;
	logic [PB-1:0] pat_waddr;
	logic        pat_in_range, lo_we, hi_we;
	logic [7:0]  lo_rd, hi_rd;
	logic [1:0]  pal_sel;
	logic [2:0]  bit_sel;
	logic [1:0]  ci;
	logic [PALETTE_AW-1:0] pidx;
	logic        pal_we;
	logic [COLOUR_W-1:0] colour_rd;

	assign cfg_ready = 1'b1;
	assign adv       = !out_valid || !out_stall;
	assign in_stall  = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			hscroll_q <= '0;
			vscroll_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ENABLE:  enable_q  <= cfg_data[0];
				CFG_HSCROLL: hscroll_q <= cfg_data;
				CFG_VSCROLL: vscroll_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: capture the input word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1.valid <= 1'b0;
		end else if (adv) begin
			item_s1 <= '{valid: in_valid, cmd: cmd_t'(cmd), addr: mem_addr, data: write_byte};
			px_s1   <= pixel_x;
			py_s1   <= pixel_y;
			ro_s1   <= row_offset;
		end
	end

	bgr_scroll #(
		.MAP_COLUMNS(MAP_COLUMNS),
		.MAP_ROWS   (MAP_ROWS)
	) u_scroll (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item_s1(item_s1),
		.px_s1  (px_s1),
		.py_s1  (py_s1),
		.ro_s1  (ro_s1),
		.hscroll(hscroll_q),
		.vscroll(vscroll_q),
		.item_s2(item_s2),
		.wx_s2  (wx_s2),
		.wy_s2  (wy_s2)
	);

	// stage 2: tile map and attribute access
	always_comb begin
		tx         = wx_s2[XB-1:3];
		ty         = wy_s2[YB-1:3];
		tile_raddr = TAB'(int'(ty) * MAP_COLUMNS + int'(tx));
		attr_raddr = ATTR_AW'((int'(ty) >> 2) * 8 + (int'(tx) >> 2));
		tile_we    = adv && item_s2.valid && (item_s2.cmd == CMD_TILE)
			&& ({1'b0, item_s2.addr} < 13'(CELLS));
		attr_we    = adv && item_s2.valid && (item_s2.cmd == CMD_ATTR)
			&& ({1'b0, item_s2.addr} < 13'(ATTR_BYTES));
	end

	bgr_ram #(.WIDTH(8), .DEPTH(CELLS)) u_tile_map (
		.clk  (clk),
		.we   (tile_we),
		.waddr(item_s2.addr[TAB-1:0]),
		.wdata(item_s2.data),
		.re   (adv),
		.raddr(tile_raddr),
		.rdata(tile_rd)
	);

	bgr_ram #(.WIDTH(8), .DEPTH(ATTR_BYTES)) u_attr_map (
		.clk  (clk),
		.we   (attr_we),
		.waddr(item_s2.addr[ATTR_AW-1:0]),
		.wdata(item_s2.data),
		.re   (adv),
		.raddr(attr_raddr),
		.rdata(attr_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s3.valid <= 1'b0;
		end else if (adv) begin
			item_s3 <= item_s2;
			fx_s3   <= wx_s2[2:0];
			fy_s3   <= wy_s2[2:0];
			sel_s3  <= {ty[1], tx[1]};
		end
	end

	// stage 3: pattern plane access and sub-palette select
	always_comb begin
		tile_wrap    = wrap_mod(13'(tile_rd), 13'(TILE_COUNT));
		pat_raddr    = {tile_wrap[TB-1:0], fy_s3};
		pat_waddr    = {item_s3.addr[TB+3:4], item_s3.addr[2:0]};
		pat_in_range = adv && item_s3.valid && (item_s3.cmd == CMD_PATTERN)
			&& ({1'b0, item_s3.addr} < 13'(PAT_BYTES));
		lo_we        = pat_in_range && !item_s3.addr[3];
		hi_we        = pat_in_range && item_s3.addr[3];
		pal_sel      = 2'(attr_rd >> {sel_s3, 1'b0});
	end

	bgr_ram #(.WIDTH(8), .DEPTH(TILE_COUNT * 8)) u_plane_lo (
		.clk  (clk),
		.we   (lo_we),
		.waddr(pat_waddr),
		.wdata(item_s3.data),
		.re   (adv),
		.raddr(pat_raddr),
		.rdata(lo_rd)
	);

	bgr_ram #(.WIDTH(8), .DEPTH(TILE_COUNT * 8)) u_plane_hi (
		.clk  (clk),
		.we   (hi_we),
		.waddr(pat_waddr),
		.wdata(item_s3.data),
		.re   (adv),
		.raddr(pat_raddr),
		.rdata(hi_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s4.valid <= 1'b0;
		end else if (adv) begin
			item_s4 <= item_s3;
			fx_s4   <= fx_s3;
			pal_s4  <= pal_sel;
		end
	end

	// stage 4: colour index and palette access
	always_comb begin
		bit_sel = ~fx_s4;
		ci      = {hi_rd[bit_sel], lo_rd[bit_sel]};
		pidx    = (ci == 2'd0) ? '0 : {1'b0, pal_s4, ci};
		pal_we  = adv && item_s4.valid && (item_s4.cmd == CMD_PALETTE)
			&& ({1'b0, item_s4.addr} < 13'(PALETTE_ENTRIES));
	end

	bgr_ram #(.WIDTH(COLOUR_W), .DEPTH(PALETTE_ENTRIES)) u_palette (
		.clk  (clk),
		.we   (pal_we),
		.waddr(item_s4.addr[PALETTE_AW-1:0]),
		.wdata(item_s4.data[COLOUR_W-1:0]),
		.re   (adv),
		.raddr(pidx),
		.rdata(colour_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s5.valid <= 1'b0;
		end else if (adv) begin
			item_s5   <= item_s4;
			opaque_s5 <= (ci != 2'd0);
		end
	end

	bgr_colour u_colour (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.enable       (enable_q),
		.item_s5      (item_s5),
		.opaque_s5    (opaque_s5),
		.colour_rd    (colour_rd),
		.out_valid    (out_valid),
		.rgb_color    (rgb_color),
		.is_opaque    (is_opaque),
		.pixel_written(pixel_written)
	);

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		(item_s5.valid && (item_s5.cmd != CMD_RENDER) && adv) |=> !out_valid)
		else $error("store write produced an output word");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(item_s5.valid && (item_s5.cmd == CMD_RENDER) && adv))
		else $error("output word without a render word in the last stage");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(item_s1.valid) && $stable(item_s3.valid)
			&& $stable(item_s5.valid)))
		else $error("pipeline moved during an output stall");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !pixel_written) |-> ((rgb_color == '0) && !is_opaque))
		else $error("disabled background gave a coloured pixel");
`endif

endmodule

// ===== test/bgr_pixel_checker.sv =====
// Pixel checker for the tile background renderer: mirrors stores and registers, predicts and compares.
`timescale 1ns / 1ps

module bgr_pixel_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [11:0] mem_addr,
	input  logic [7:0]  write_byte,
	input  logic [7:0]  pixel_x,
	input  logic [7:0]  pixel_y,
	input  logic [7:0]  row_offset,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [23:0] rgb_color,
	input  logic        is_opaque,
	input  logic        pixel_written,
	output int          fail_count,
	output int          pending,
	output int          checked
);

	import bgr_pkg::*;

	localparam int MAP_COLUMNS   = 32;
	localparam int MAP_CELLS     = 32 * 30;
	localparam int PATTERN_BYTES = 256 * 16;
	localparam int REPORT_MAX    = 10;

	localparam logic [64*24-1:0] COLOUR_ROM = {
		24'h545454, 24'h001E74, 24'h081090, 24'h300088, 24'h440064, 24'h5C0030, 24'h540400, 24'h3C1800,
		24'h202A00, 24'h083A00, 24'h004000, 24'h003C00, 24'h00323C, 24'h000000, 24'h000000, 24'h000000,
		24'h989698, 24'h084CC4, 24'h3032EC, 24'h5C1EE4, 24'h8800B0, 24'hA00060, 24'h981A20, 24'h783C00,
		24'h545A00, 24'h207200, 24'h007C00, 24'h007628, 24'h006678, 24'h000000, 24'h000000, 24'h000000,
		24'hECEEEC, 24'h4C9AEC, 24'h787CEC, 24'hB062EC, 24'hE400DC, 24'hEC0078, 24'hEC3C30, 24'hCC6C00,
		24'h8C9000, 24'h48A800, 24'h10B800, 24'h00B260, 24'h00A2C4, 24'h4C4C4C, 24'h000000, 24'h000000,
		24'hECEEEC, 24'hA8CCEC, 24'hBCBCEC, 24'hD4B2EC, 24'hECAEEC, 24'hECAED4, 24'hECB4B0, 24'hE4C490,
		24'hCCD278, 24'hB4DE78, 24'hA8E290, 24'h98E2B4, 24'hA0D6E4, 24'hA0A2A0, 24'h000000, 24'h000000
	};

	typedef struct packed {
		logic [23:0] rgb;
		logic        opaque;
		logic        written;
	} pixel_t;

	logic [7:0] tile_no   [MAP_CELLS];
	logic [7:0] attr_byte [ATTR_BYTES];
	logic [7:0] plane_row [PATTERN_BYTES];
	logic [5:0] colour_no [PALETTE_ENTRIES];
	logic       bg_on   = 1'b0;
	logic [7:0] h_shift = '0;
	logic [7:0] v_shift = '0;
	pixel_t     pixels_due [$];
	pixel_t     want;
	pixel_t     got;
	int         errs = 0;
	int         seen = 0;

	function automatic logic [23:0] colour_of(input logic [5:0] c);
		return COLOUR_ROM[(63 - int'(c)) * 24 +: 24];
	endfunction

	function automatic pixel_t shade(input logic [7:0] px, input logic [7:0] py,
			input logic [7:0] ro);
		logic [7:0]  wx;
		logic [8:0]  wy;
		logic [4:0]  tx;
		logic [4:0]  ty;
		logic [2:0]  fx;
		logic [2:0]  fy;
		logic [9:0]  map_idx;
		logic [11:0] row_addr;
		logic [1:0]  ci;
		logic [1:0]  sub;
		pixel_t      p;
		p = '0;
		if (!bg_on) begin
			return p;
		end
		wx = px + h_shift + ro;
		wy = py + v_shift;
		while (wy >= 9'd240) begin
			wy = wy - 9'd240;
		end
		tx = wx[7:3];
		ty = wy[7:3];
		fx = wx[2:0];
		fy = wy[2:0];
		map_idx = 10'(int'(ty) * MAP_COLUMNS + int'(tx));
		row_addr = {tile_no[map_idx], 1'b0, fy};
		ci = {plane_row[row_addr + 12'd8][~fx], plane_row[row_addr][~fx]};
		if (ci == 2'd0) begin
			p.rgb = colour_of(colour_no[5'd0]);
		end else begin
			sub = 2'(attr_byte[{ty[4:2], tx[4:2]}] >> {ty[1], tx[1], 1'b0});
			p.rgb = colour_of(colour_no[{1'b0, sub, ci}]);
			p.opaque = 1'b1;
		end
		p.written = 1'b1;
		return p;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			bg_on = 1'b0;
			h_shift = '0;
			v_shift = '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_ENABLE:  bg_on = cfg_data[0];
					CFG_HSCROLL: h_shift = cfg_data;
					CFG_VSCROLL: v_shift = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				seen++;
				got = {rgb_color, is_opaque, pixel_written};
				if (pixels_due.size() == 0) begin
					errs++;
					if (errs <= REPORT_MAX) begin
						$display("checker: pixel word %0d arrived with none expected (rgb %06h)",
							seen, rgb_color);
					end
				end else begin
					want = pixels_due.pop_front();
					if (got !== want) begin
						errs++;
						if (errs <= REPORT_MAX) begin
							$display({"checker: pixel word %0d: rgb %06h exp %06h,",
								" opaque %0b exp %0b, written %0b exp %0b"},
								seen, got.rgb, want.rgb, got.opaque, want.opaque,
								got.written, want.written);
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				case (cmd)
					CMD_RENDER:  pixels_due.push_back(shade(pixel_x, pixel_y, row_offset));
					CMD_TILE: begin
						if ({1'b0, mem_addr} < 13'(MAP_CELLS))
							tile_no[mem_addr[9:0]] = write_byte;
					end
					CMD_ATTR: begin
						if ({1'b0, mem_addr} < 13'(ATTR_BYTES))
							attr_byte[mem_addr[5:0]] = write_byte;
					end
					CMD_PATTERN: begin
						if ({1'b0, mem_addr} < 13'(PATTERN_BYTES))
							plane_row[mem_addr] = write_byte;
					end
					CMD_PALETTE: begin
						if ({1'b0, mem_addr} < 13'(PALETTE_ENTRIES))
							colour_no[mem_addr[4:0]] = write_byte[5:0];
					end
					default: ;
				endcase
			end
		end
		fail_count <= errs;
		pending <= pixels_due.size();
		checked <= seen;
	end

endmodule

// ===== test/tb.sv =====
// Testbench top for the tile background renderer: stimulus, flow control, watchdog and verdict.
`timescale 1ns / 1ps

module tb;

	import bgr_pkg::*;

	localparam int ITEMS        = 1100;
	localparam int PHASES       = 9;
	localparam int QUIET_MAX    = 3000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAP_CELLS    = 960;
	localparam int PATTERN_LAST = 4095;
	localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index     = '0;
	logic [7:0]  cfg_data      = '0;
	logic        in_valid      = 1'b0;
	logic        in_stall;
	logic [2:0]  cmd           = '0;
	logic [11:0] mem_addr      = '0;
	logic [7:0]  write_byte    = '0;
	logic [7:0]  pixel_x       = '0;
	logic [7:0]  pixel_y       = '0;
	logic [7:0]  row_offset    = '0;
	logic        out_valid;
	logic        out_stall     = 1'b0;
	logic [23:0] rgb_color;
	logic        is_opaque;
	logic        pixel_written;
	int          fail_count;
	int          pending;
	int          checked;

	int          send_idle_pct = 17;
	int          stall_pct     = 72;
	logic        hold_go       = 1'b0;
	logic        hold_done     = 1'b0;
	int          hold_left     = 0;
	int          quiet         = 0;

	logic [7:0]  tile_val [MAP_CELLS];
	bit          tile_set [MAP_CELLS];
	logic [7:0]  attr_val [ATTR_BYTES];
	bit          attr_set [ATTR_BYTES];
	bit          pat_set  [PATTERN_LAST + 1];
	bit          pal_set  [PALETTE_ENTRIES];
	logic        en_r = 1'b0;
	logic [7:0]  hs_r = '0;
	logic [7:0]  vs_r = '0;
	int          words = 0;
	int          dropped = 0;
	int          renders = 0;
	int          lit = 0;
	int          settings = 0;

	tile_background_pixel_renderer_top i_dut (.*);
	bgr_pixel_checker i_check (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_go && !hold_done) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet == QUIET_MAX) begin
			$display("tb: watchdog expired after %0d cycles with no word moving", QUIET_MAX);
			$display("tb: failure");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function automatic int pick_tile();
		return ($urandom_range(0, 99) < 80) ? $urandom_range(0, 15) : $urandom_range(0, 255);
	endfunction

	function automatic int store_addr(input int last);
		return ($urandom_range(0, 9) != 0) ? $urandom_range(0, last) : $urandom_range(0, PATTERN_LAST);
	endfunction

	task automatic push_word(input logic [2:0] c, input logic [11:0] a, input logic [7:0] b,
			input logic [7:0] x, input logic [7:0] y, input logic [7:0] r);
		in_valid <= 1'b1;
		cmd <= c;
		mem_addr <= a;
		write_byte <= b;
		pixel_x <= x;
		pixel_y <= y;
		row_offset <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		words++;
		case (c)
			CMD_RENDER: begin
				renders++;
				if (en_r) lit++;
			end
			CMD_TILE: begin
				if (a < 12'(MAP_CELLS)) begin
					tile_val[a[9:0]] = b;
					tile_set[a[9:0]] = 1'b1;
				end else begin
					dropped++;
				end
			end
			CMD_ATTR: begin
				if (a < 12'(ATTR_BYTES)) begin
					attr_val[a[5:0]] = b;
					attr_set[a[5:0]] = 1'b1;
				end else begin
					dropped++;
				end
			end
			CMD_PATTERN: pat_set[a] = 1'b1;
			CMD_PALETTE: begin
				if (a < 12'(PALETTE_ENTRIES)) pal_set[a[4:0]] = 1'b1;
				else dropped++;
			end
			default: dropped++;
		endcase
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
	endtask

	task automatic write_store(input logic [2:0] c, input logic [11:0] a, input logic [7:0] b);
		push_word(c, a, b, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 239)),
			8'($urandom_range(0, 255)));
	endtask

	// fill whatever this pixel will read before rendering it
	task automatic render_at(input logic [7:0] x, input logic [7:0] y, input logic [7:0] r);
		logic [7:0]  wx;
		logic [8:0]  wy;
		logic [9:0]  map_idx;
		logic [11:0] row_addr;
		logic [5:0]  aidx;
		logic [1:0]  sub;
		logic [4:0]  pal_idx;
		logic [2:0]  k;
		wx = x + hs_r + r;
		wy = y + vs_r;
		while (wy >= 9'd240) begin
			wy = wy - 9'd240;
		end
		map_idx = 10'(wy[7:3] * 32 + wx[7:3]);
		if (!tile_set[map_idx]) write_store(CMD_TILE, 12'(map_idx), 8'(pick_tile()));
		row_addr = {tile_val[map_idx], 1'b0, wy[2:0]};
		if (!pat_set[row_addr]) write_store(CMD_PATTERN, row_addr, 8'($urandom_range(0, 255)));
		if (!pat_set[row_addr + 12'd8])
			write_store(CMD_PATTERN, row_addr + 12'd8, 8'($urandom_range(0, 255)));
		aidx = {wy[7:5], wx[7:5]};
		if (!attr_set[aidx]) write_store(CMD_ATTR, 12'(aidx), 8'($urandom_range(0, 255)));
		sub = 2'(attr_val[aidx] >> {wy[4], wx[4], 1'b0});
		for (k = 0; k < 4; k++) begin
			pal_idx = {1'b0, sub, k[1:0]};
			if (!pal_set[pal_idx])
				write_store(CMD_PALETTE, 12'(pal_idx), 8'($urandom_range(0, 255)));
		end
		if (!pal_set[0]) write_store(CMD_PALETTE, 12'd0, 8'($urandom_range(0, 255)));
		push_word(CMD_RENDER, 12'($urandom_range(0, PATTERN_LAST)), 8'($urandom_range(0, 255)),
			x, y, r);
	endtask

	task automatic random_word();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			render_at(8'($urandom_range(0, 255)), 8'($urandom_range(0, 239)),
				$urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(0, 255)));
		end else if (roll < 70) begin
			write_store(CMD_TILE, 12'(store_addr(MAP_CELLS - 1)), 8'(pick_tile()));
		end else if (roll < 77) begin
			write_store(CMD_ATTR, 12'(store_addr(ATTR_BYTES - 1)), 8'($urandom_range(0, 255)));
		end else if (roll < 89) begin
			write_store(CMD_PATTERN, ($urandom_range(0, 3) != 0) ? 12'($urandom_range(0, 255))
				: 12'($urandom_range(0, PATTERN_LAST)), 8'($urandom_range(0, 255)));
		end else if (roll < 96) begin
			write_store(CMD_PALETTE, 12'(store_addr(PALETTE_ENTRIES - 1)),
				8'($urandom_range(0, 255)));
		end else begin
			write_store(3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)),
				12'($urandom_range(0, PATTERN_LAST)), 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic e, input logic [7:0] h, input logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_ENABLE;
		cfg_data <= {7'd0, e};
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_HSCROLL;
		cfg_data <= h;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_VSCROLL;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		en_r = e;
		hs_r = h;
		vs_r = v;
		settings++;
	endtask

	initial begin
		int k;
		int target;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// background off after reset; edge addresses, ignored writes and spare commands
		write_store(CMD_PALETTE, 12'd0, 8'hFF);
		write_store(CMD_PALETTE, 12'(PALETTE_ENTRIES - 1), 8'hC0);
		write_store(CMD_TILE, 12'd0, 8'h00);
		write_store(CMD_TILE, 12'(MAP_CELLS - 1), 8'hFF);
		write_store(CMD_ATTR, 12'd0, 8'hE4);
		write_store(CMD_ATTR, 12'(ATTR_BYTES - 1), 8'hFF);
		write_store(CMD_PATTERN, 12'd0, 8'h80);
		write_store(CMD_PATTERN, 12'd8, 8'h01);
		write_store(CMD_TILE, 12'(MAP_CELLS), 8'h5A);
		write_store(CMD_ATTR, 12'(ATTR_BYTES), 8'hA5);
		write_store(CMD_PALETTE, 12'(PATTERN_LAST), 8'h3C);
		write_store(CMD_SPARE_FIRST, 12'd0, 8'h11);
		write_store(CMD_SPARE_FIRST + 3'd1, 12'h800, 8'h22);
		write_store(CMD_SPARE_LAST, 12'(PATTERN_LAST), 8'h33);
		render_at(8'd255, 8'd239, 8'd255);
		drain();

		// both scrolls at their top, so every pixel but the first wraps
		set_config(1'b1, 8'd255, 8'd239);
		render_at(8'd0, 8'd0, 8'd0);
		render_at(8'd255, 8'd239, 8'd255);
		render_at(8'd1, 8'd1, 8'd0);
		render_at(8'd0, 8'd0, 8'd1);
		drain();
		set_config(1'b1, 8'd0, 8'd0);
		render_at(8'd0, 8'd0, 8'd0);
		render_at(8'd255, 8'd239, 8'd255);
		render_at(8'd7, 8'd8, 8'd0);

		for (k = 0; k < PHASES; k++) begin
			drain();
			if (k == 3) begin
				send_idle_pct = 72;
				stall_pct <= 17;
			end
			if (k == 6) begin
				send_idle_pct = 0;
				stall_pct <= 0;
			end
			set_config(k != 3,
				(k == 0) ? 8'd0 : (k == 1) ? 8'd255 : 8'($urandom_range(0, 255)),
				(k == 0) ? 8'd239 : (k == 1) ? 8'd0 : 8'($urandom_range(0, 239)));
			if (k == 7) hold_go <= 1'b1;
			target = (k + 1) * ITEMS / PHASES;
			while (words - dropped < target) random_word();
		end
		drain();

		$display("tb: run covered %0d words: %0d renders (%0d with background on), %0d ignored",
			words, renders, lit, dropped);
		$display("tb: %0d register settings, %0d pixels checked, %0d mismatches",
			settings, checked, fail_count);
		if (fail_count == 0 && pending == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
